/* src/assert_macros.svh */
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// overlapping implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* src/rtpsep_pkg.sv */
// package with constants and types for the endpoint parameter parser
package rtpsep_pkg;

  localparam logic [15:0] PidSentinel    = 16'h0001;
  localparam logic [15:0] PidTopic       = 16'h0005;
  localparam logic [15:0] PidType        = 16'h0007;
  localparam logic [15:0] PidReliability = 16'h001A;
  localparam logic [15:0] PidDurability  = 16'h001D;
  localparam logic [15:0] PidLocator     = 16'h002F;
  localparam logic [15:0] PidGuid        = 16'h005A;
  localparam logic [15:0] LocatorSize    = 16'd24;
  localparam logic [15:0] GuidSize       = 16'd16;
  localparam logic [5:0]  AllSeen        = 6'h3F;

  // register indexes
  localparam logic [1:0] RegRelBe  = 2'd0;
  localparam logic [1:0] RegRelRel = 2'd1;
  localparam logic [1:0] RegDurVol = 2'd2;
  localparam logic [1:0] RegDurTl  = 2'd3;

  // status codes
  localparam logic [4:0] StOk         = 5'd0;
  localparam logic [4:0] StShort      = 5'd1;
  localparam logic [4:0] StBadHeader  = 5'd2;
  localparam logic [4:0] StSentLen    = 5'd3;
  localparam logic [4:0] StOverrun    = 5'd4;
  localparam logic [4:0] StGuidSize   = 5'd5;
  localparam logic [4:0] StEntityZero = 5'd6;
  localparam logic [4:0] StStrShort   = 5'd7;
  localparam logic [4:0] StStrBad     = 5'd8;
  localparam logic [4:0] StLocSize    = 5'd9;
  localparam logic [4:0] StLocKind    = 5'd10;
  localparam logic [4:0] StLocAddr    = 5'd11;
  localparam logic [4:0] StLocPort    = 5'd12;
  localparam logic [4:0] StRelBad     = 5'd13;
  localparam logic [4:0] StDurBad     = 5'd14;
  localparam logic [4:0] StNoSentinel = 5'd15;
  localparam logic [4:0] StMissing    = 5'd16;

  // record kinds
  localparam logic [1:0] KindTopic = 2'd0;
  localparam logic [1:0] KindType  = 2'd1;
  localparam logic [1:0] KindFinal = 2'd2;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PARAM_HEAD,
    PH_VALUE,
    PH_DONE
  } phase_e;

  typedef struct packed {
    logic [31:0] rel_be;
    logic [31:0] rel_rel;
    logic [31:0] dur_vol;
    logic [31:0] dur_tl;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  name_char;
    logic        restart;
    logic [4:0]  status;
    logic [63:0] prefix_high;
    logic [31:0] prefix_low;
    logic [31:0] entity_word;
    logic [31:0] ipv4_address;
    logic [15:0] udp_port;
    logic [31:0] rel_value;
    logic [31:0] dur_value;
  } rec_t;

  // result tdata width, padded to bytes (8+1+5+64+32+32+32+16+32+32 = 254)
  localparam int unsigned RecBits = 256;

  function automatic logic [4:0] lower_error(logic [4:0] cur, logic [4:0] code);
    if (cur == StOk || code < cur) return code;
    return cur;
  endfunction

endpackage

/* src/rtpsep_cfg_regs.sv */
// configuration registers holding the accepted qos kind values
module rtpsep_cfg_regs (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [31:0]          cfg_wdata_i,
  output rtpsep_pkg::cfg_t     cfg_o
);
  import rtpsep_pkg::*;

  cfg_t cfg_q;

  // register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rel_be  <= 32'd1;
      cfg_q.rel_rel <= 32'd2;
      cfg_q.dur_vol <= 32'd0;
      cfg_q.dur_tl  <= 32'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegRelBe:  cfg_q.rel_be  <= cfg_wdata_i;
        RegRelRel: cfg_q.rel_rel <= cfg_wdata_i;
        RegDurVol: cfg_q.dur_vol <= cfg_wdata_i;
        RegDurTl:  cfg_q.dur_tl  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;
endmodule

/* src/rtpsep_core.sv */
// per-byte parse step: state registers and next-record logic
module rtpsep_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  input  logic              last_i,
  input  rtpsep_pkg::cfg_t  cfg_i,
  output logic              rec_valid_o,
  output rtpsep_pkg::rec_t  rec_o
);
  import rtpsep_pkg::*;

  phase_e      phase_q, phase_d;
  logic [2:0]  hcnt_q, hcnt_d;
  logic        hbad_q, hbad_d;
  logic [15:0] pid_q, pid_d;
  logic [15:0] plen_q, plen_d;
  logic [15:0] pos_q, pos_d;
  logic [4:0]  perr_q, perr_d;
  logic [5:0]  seen_q, seen_d;
  logic [31:0] word_q, word_d;
  logic [63:0] gh_q, gh_d;
  logic [63:0] gl_q, gl_d;
  logic [31:0] addr_q, addr_d;
  logic [15:0] port_q, port_d;
  logic [31:0] rel_q, rel_d;
  logic [31:0] dur_q, dur_d;

  logic [31:0] wnew;
  logic [1:0]  hp;
  logic [16:0] padded;
  logic [16:0] pos1;
  logic [16:0] lenm1;
  logic [7:0]  hexp;
  logic [4:0]  fin_err;
  logic        emit;
  logic        is_final;
  logic [4:0]  st;
  logic [1:0]  ckind;

  // error of a completed parameter, zero when it is clean
  function automatic logic [4:0] fin_code(logic [4:0] pe);
    return pe;
  endfunction

  always_comb begin
    phase_d = phase_q; hcnt_d = hcnt_q; hbad_d = hbad_q; pid_d = pid_q;
    plen_d = plen_q; pos_d = pos_q; perr_d = perr_q; seen_d = seen_q;
    word_d = word_q; gh_d = gh_q; gl_d = gl_q; addr_d = addr_q; port_d = port_q;
    rel_d = rel_q; dur_d = dur_q;
    emit = 1'b0; is_final = 1'b0; st = StOk; ckind = KindTopic;
    wnew = 32'd0; fin_err = StOk;
    hp = pos_q[1:0];
    padded = ({1'b0, plen_q} + 17'd3) & ~17'd3;
    pos1 = {1'b0, pos_q} + 17'd1;
    lenm1 = {1'b0, plen_q} - 17'd1;
    unique case (hcnt_q[1:0])
      2'd1:    hexp = 8'h03;
      default: hexp = 8'h00;
    endcase
    if (step_i) begin
      unique case (phase_q)
        PH_HEADER: begin
          if (byte_i != hexp) hbad_d = 1'b1;
          hcnt_d = hcnt_q + 3'd1;
          if (hcnt_d >= 3'd4) begin
            hcnt_d = 3'd4; phase_d = PH_PARAM_HEAD; pos_d = 16'd0;
          end
          if (last_i) begin is_final = 1'b1; st = StShort; end
        end
        PH_PARAM_HEAD: begin
          wnew = (hp == 2'd0) ? 32'd0 : word_q;
          wnew = wnew | ({24'd0, byte_i} << {hp, 3'b000});
          word_d = wnew;
          if (hp != 2'd3) begin
            pos_d = {14'd0, hp + 2'd1};
            if (last_i) begin
              is_final = 1'b1; st = (hcnt_q == 3'd4) ? StShort : StNoSentinel;
            end
          end else begin
            pos_d = 16'd0;
            pid_d = wnew[15:0];
            plen_d = wnew[31:16];
            if (hcnt_q == 3'd4) hcnt_d = 3'd5;
            if (hcnt_q == 3'd4 && hbad_q) begin
              is_final = 1'b1; st = StBadHeader;
            end else if (wnew[15:0] == PidSentinel) begin
              is_final = 1'b1;
              if (wnew[31:16] != 16'd0) st = StSentLen;
              else st = (seen_q == AllSeen) ? StOk : StMissing;
            end else begin
              perr_d = StOk;
              unique case (wnew[15:0])
                PidGuid:        if (wnew[31:16] != GuidSize) perr_d = StGuidSize;
                PidTopic,
                PidType:        if (wnew[31:16] < 16'd5) perr_d = StStrShort;
                PidLocator:     if (wnew[31:16] != LocatorSize) perr_d = StLocSize;
                PidReliability: if (wnew[31:16] != 16'd4) perr_d = StRelBad;
                PidDurability:  if (wnew[31:16] != 16'd4) perr_d = StDurBad;
                default: ;
              endcase
              if (wnew[31:16] == 16'd0) begin
                fin_err = fin_code(perr_d);
                if (fin_err != StOk) begin is_final = 1'b1; st = fin_err; end
                else begin
                  unique case (wnew[15:0])
                    PidGuid:        seen_d[0] = 1'b1;
                    PidTopic:       seen_d[1] = 1'b1;
                    PidType:        seen_d[2] = 1'b1;
                    PidLocator:     seen_d[3] = 1'b1;
                    PidReliability: seen_d[4] = 1'b1;
                    PidDurability:  seen_d[5] = 1'b1;
                    default: ;
                  endcase
                  if (last_i) begin is_final = 1'b1; st = StNoSentinel; end
                end
              end else if (last_i) begin
                is_final = 1'b1; st = StOverrun;
              end else begin
                phase_d = PH_VALUE;
              end
            end
          end
        end
        PH_VALUE: begin
          // value byte decode
          if ({1'b0, pos_q} < {1'b0, plen_q}) begin
            if (pos_q < 16'd4) begin
              wnew = (pos_q[1:0] == 2'd0) ? 32'd0 : word_q;
              wnew = wnew | ({24'd0, byte_i} << {pos_q[1:0], 3'b000});
              word_d = wnew;
            end else begin
              wnew = word_q;
            end
            unique case (pid_q)
              PidGuid: begin
                if (pos_q < 16'd8)
                  gh_d[{~pos_q[2:0], 3'b000} +: 8] = byte_i;
                else if (pos_q < 16'd16)
                  gl_d[{~pos_q[2:0], 3'b000} +: 8] = byte_i;
                if (pos_q == 16'd15 && gl_d[31:0] == 32'd0)
                  perr_d = lower_error(perr_d, StEntityZero);
              end
              PidTopic, PidType: begin
                if (plen_q >= 16'd5 && {1'b0, pos_q} == lenm1) begin
                  if (wnew == 32'd0 || ({1'b0, wnew} + 33'd4) != {17'd0, plen_q}
                      || byte_i != 8'd0)
                    perr_d = lower_error(perr_d, StStrBad);
                end
              end
              PidLocator: begin
                if (pos_q == 16'd3 && wnew != 32'd1) perr_d = lower_error(perr_d, StLocKind);
                if (pos_q == 16'd4) port_d[7:0] = byte_i;
                if (pos_q == 16'd5) port_d[15:8] = byte_i;
                if ((pos_q == 16'd6 || pos_q == 16'd7) && byte_i != 8'd0)
                  perr_d = lower_error(perr_d, StLocPort);
                if (pos_q >= 16'd8 && pos_q < 16'd20 && byte_i != 8'd0)
                  perr_d = lower_error(perr_d, StLocAddr);
                if (pos_q >= 16'd20 && pos_q < 16'd24)
                  addr_d[{~pos_q[1:0], 3'b000} +: 8] = byte_i;
              end
              PidReliability: begin
                if (pos_q == 16'd3) begin
                  rel_d = wnew;
                  if (wnew != cfg_i.rel_be && wnew != cfg_i.rel_rel)
                    perr_d = lower_error(perr_d, StRelBad);
                end
              end
              PidDurability: begin
                if (pos_q == 16'd3) begin
                  dur_d = wnew;
                  if (wnew != cfg_i.dur_vol && wnew != cfg_i.dur_tl)
                    perr_d = lower_error(perr_d, StDurBad);
                end
              end
              default: ;
            endcase
          end
          if (pos1 >= padded) begin
            phase_d = PH_PARAM_HEAD; pos_d = 16'd0;
            if (perr_d != StOk) begin is_final = 1'b1; st = perr_d; end
            else begin
              unique case (pid_q)
                PidGuid:        seen_d[0] = 1'b1;
                PidTopic:       seen_d[1] = 1'b1;
                PidType:        seen_d[2] = 1'b1;
                PidLocator:     seen_d[3] = 1'b1;
                PidReliability: seen_d[4] = 1'b1;
                PidDurability:  seen_d[5] = 1'b1;
                default: ;
              endcase
              if (last_i) begin is_final = 1'b1; st = StNoSentinel; end
            end
          end else if (last_i) begin
            is_final = 1'b1; st = StOverrun;
          end else begin
            pos_d = pos1[15:0];
            if ((pid_q == PidTopic || pid_q == PidType) && plen_q >= 16'd5 &&
                pos_q >= 16'd4 && {1'b0, pos_q} < lenm1) begin
              emit = 1'b1;
              ckind = (pid_q == PidTopic) ? KindTopic : KindType;
            end
          end
        end
        default: ;
      endcase
      if (is_final) phase_d = PH_DONE;
    end
  end

  // result build
  always_comb begin
    rec_o = '0;
    if (is_final) begin
      rec_o.kind = KindFinal;
      rec_o.status = st;
      rec_o.prefix_high = gh_d;
      rec_o.prefix_low = gl_d[63:32];
      rec_o.entity_word = gl_d[31:0];
      rec_o.ipv4_address = addr_d;
      rec_o.udp_port = port_d;
      rec_o.rel_value = rel_d;
      rec_o.dur_value = dur_d;
    end else begin
      rec_o.kind = ckind;
      rec_o.name_char = byte_i;
      rec_o.restart = (pos_q == 16'd4);
    end
  end
  assign rec_valid_o = step_i && (is_final || emit);

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER; hcnt_q <= '0; hbad_q <= 1'b0; pid_q <= '0; plen_q <= '0;
      pos_q <= '0; perr_q <= '0; seen_q <= '0; word_q <= '0; gh_q <= '0; gl_q <= '0;
      addr_q <= '0; port_q <= '0; rel_q <= '0; dur_q <= '0;
    end else begin
      phase_q <= phase_d; hcnt_q <= hcnt_d; hbad_q <= hbad_d; pid_q <= pid_d;
      plen_q <= plen_d; pos_q <= pos_d; perr_q <= perr_d; seen_q <= seen_d;
      word_q <= word_d; gh_q <= gh_d; gl_q <= gl_d; addr_q <= addr_d;
      port_q <= port_d; rel_q <= rel_d; dur_q <= dur_d;
    end
  end
endmodule

/* src/rtps_endpoint_param_parser_unit.sv */
// top level of the endpoint parameter parser
// Parses a discovery parameter list one byte per transfer and accepts a
// byte in every cycle that s_axis_tready is high. Each byte is registered
// at the input, decoded in one step and its record, if any, lands in a
// two-entry output buffer in the next cycle. s_axis_tready drops only while
// that buffer cannot take another record. After the final record the block
// keeps accepting bytes and drops them until reset.
module rtps_endpoint_param_parser_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [7:0]    s_axis_tdata,   // payload_byte
  input  logic          s_axis_tlast,   // end_of_payload
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [255:0]  m_axis_tdata,   // char, restart, status, prefix_high, prefix_low,
                                        // entity, addr, port, rel, dur (lsb..msb)
  output logic [1:0]    m_axis_tuser,   // record kind
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_index_i,
  input  logic [31:0]   cfg_wdata_i
);
  import rtpsep_pkg::*;

  cfg_t        cfg;
  logic        in_v_q;
  logic [7:0]  in_b_q;
  logic        in_l_q;
  logic        rv;
  rec_t        rec;
  rec_t        buf_q [2];
  logic [1:0]  cnt_q;
  logic        rd_q, wr_q;
  logic        push, pop;

  rtpsep_cfg_regs u_cfg (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i, .cfg_o(cfg)
  );

  // input register, counts a record leaving the buffer in the same cycle
  assign s_axis_tready = (cnt_q == 2'd0) || (cnt_q == 2'd1 && (!in_v_q || pop)) ||
                         (cnt_q == 2'd2 && !in_v_q && pop);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) in_v_q <= 1'b0;
    else in_v_q <= s_axis_tvalid && s_axis_tready;
  end
  always_ff @(posedge clk_i) begin
    in_b_q <= s_axis_tdata;
    in_l_q <= s_axis_tlast;
  end

  rtpsep_core u_core (
    .clk_i, .rst_ni, .step_i(in_v_q), .byte_i(in_b_q), .last_i(in_l_q),
    .cfg_i(cfg), .rec_valid_o(rv), .rec_o(rec)
  );

  // two-entry output buffer
  assign push = rv;
  assign pop = m_axis_tvalid && m_axis_tready;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; rd_q <= 1'b0; wr_q <= 1'b0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
  always_ff @(posedge clk_i) begin
    if (push) buf_q[wr_q] <= rec;
  end
  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tuser = buf_q[rd_q].kind;
  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[7:0] = buf_q[rd_q].name_char;
    m_axis_tdata[8] = buf_q[rd_q].restart;
    m_axis_tdata[13:9] = buf_q[rd_q].status;
    m_axis_tdata[77:14] = buf_q[rd_q].prefix_high;
    m_axis_tdata[109:78] = buf_q[rd_q].prefix_low;
    m_axis_tdata[141:110] = buf_q[rd_q].entity_word;
    m_axis_tdata[173:142] = buf_q[rd_q].ipv4_address;
    m_axis_tdata[189:174] = buf_q[rd_q].udp_port;
    m_axis_tdata[221:190] = buf_q[rd_q].rel_value;
    m_axis_tdata[253:222] = buf_q[rd_q].dur_value;
  end
endmodule

/* src/rtpsep_checker.sv */
// port-level checker for the endpoint parameter parser, bound to the top
`include "assert_macros.svh"
module rtpsep_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [255:0] m_axis_tdata,
  input logic [1:0]   m_axis_tuser
);
  import rtpsep_pkg::*;

  `ASSERT_IMPL(a_kind_range, clk_i, rst_ni, m_axis_tvalid, m_axis_tuser <= KindFinal)
  `ASSERT_IMPL(a_char_st, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser != KindFinal, m_axis_tdata[13:9] == StOk)
  `ASSERT_IMPL(a_status_range, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[13:9] <= StMissing)
  `ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
endmodule

bind rtps_endpoint_param_parser_unit rtpsep_checker u_chk (
  .clk_i, .rst_ni, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
);
